// ===== rtl/mec_pkg.sv =====
`timescale 1ns / 1ps
// mec_pkg: shared types and constants of the escape classifier
// holds fixed-point constants, register indexes, region codes and fsm states
// no dependencies
package mec_pkg;

    // q4.28 fixed-point format
    localparam int unsigned Q_W        = 32;
    localparam int unsigned FRAC_W     = 28;
    localparam int unsigned STEP_W     = 28;
    localparam int unsigned COLOR_W    = 24;
    localparam int unsigned PROD_W     = 64;
    // width of the update sum before saturation
    localparam int unsigned SUM_W      = 37;

    // offsets that shift the pixel grid onto the complex plane
    localparam logic [63:0] RE_OFFSET  = 64'd402653184;   // 1.5 in q4.28
    localparam logic [63:0] IM_OFFSET  = 64'd268435456;   // 1.0 in q4.28
    // largest product that still maps inside q4.28 after the offset
    localparam logic [63:0] RE_SAT_LIM = 64'd2550136831;
    localparam logic [63:0] IM_SAT_LIM = 64'd2415919103;
    localparam logic [Q_W-1:0] Q_MAX   = 32'h7fff_ffff;
    localparam logic [Q_W-1:0] Q_MIN   = 32'h8000_0000;

    // configuration port
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 28;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ITER_LIMIT    = 3'd0,
        CFG_REAL_STEP     = 3'd1,
        CFG_IMAG_STEP     = 3'd2,
        CFG_INSIDE_COLOR  = 3'd3,
        CFG_RIM_COLOR     = 3'd4,
        CFG_OUTSIDE_COLOR = 3'd5
    } t_cfg_addr;

    // register values after reset
    localparam int unsigned          RST_ITER_LIMIT    = 100;
    localparam logic [STEP_W-1:0]    RST_REAL_STEP     = 28'd536871;
    localparam logic [STEP_W-1:0]    RST_IMAG_STEP     = 28'd536871;
    localparam logic [COLOR_W-1:0]   RST_INSIDE_COLOR  = 24'h000000;
    localparam logic [COLOR_W-1:0]   RST_RIM_COLOR     = 24'hffffff;
    localparam logic [COLOR_W-1:0]   RST_OUTSIDE_COLOR = 24'h0000ff;

    // result region codes
    typedef enum logic [1:0] {
        REGION_OUTSIDE = 2'd0,
        REGION_RIM     = 2'd1,
        REGION_INSIDE  = 2'd2
    } t_region;

    // iteration engine states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_MUL  = 2'd1,
        S_UPD  = 2'd2,
        S_DONE = 2'd3
    } t_eng_state;

    // point c handed from the front end to the engine
    typedef struct packed {
        logic signed [Q_W-1:0] c_re;
        logic signed [Q_W-1:0] c_im;
    } t_point;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // color registers used by the engine
    typedef struct packed {
        logic [COLOR_W-1:0] inner;
        logic [COLOR_W-1:0] rim;
        logic [COLOR_W-1:0] outside;
    } t_colors;

    localparam int unsigned QUEUE_DEPTH = 2;

endpackage

// ===== rtl/mec_front.sv =====
`timescale 1ns / 1ps
// mec_front: accepts pixel transactions and maps row and column to point c
// two stages: step multiply, then offset and saturation into the queue
// depends on mec_pkg
module mec_front #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [COORD_BITS-1:0]           i_row,
    input  logic [COORD_BITS-1:0]           i_column,
    input  logic [mec_pkg::STEP_W-1:0]      i_real_step,
    input  logic [mec_pkg::STEP_W-1:0]      i_imag_step,
    input  mec_pkg::t_queue_status          i_q_status,
    output logic                            o_push,
    output mec_pkg::t_point                 o_point
);

    localparam int unsigned PW = COORD_BITS + mec_pkg::STEP_W;
    localparam logic [PW-1:0] RE_LIM = PW'(mec_pkg::RE_SAT_LIM);
    localparam logic [PW-1:0] IM_LIM = PW'(mec_pkg::IM_SAT_LIM);
    localparam logic [PW-1:0] RE_OFF = PW'(mec_pkg::RE_OFFSET);
    localparam logic [PW-1:0] IM_OFF = PW'(mec_pkg::IM_OFFSET);

    logic          r_valid;
    logic [PW-1:0] r_prod_re;
    logic [PW-1:0] r_prod_im;
    logic [PW-1:0] w_diff_re;
    logic [PW-1:0] w_diff_im;
    logic          w_accept;

    // stage one moves on whenever it is empty or its product has left for the queue
    assign o_push   = r_valid && !i_q_status.full;
    assign o_ready  = !r_valid || !i_q_status.full;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // step products, payload only
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prod_re <= PW'(i_column) * PW'(i_real_step);
            r_prod_im <= PW'(i_row) * PW'(i_imag_step);
        end
    end

    // subtract the offset, clamp at the top of the q4.28 range
    assign w_diff_re = r_prod_re - RE_OFF;
    assign w_diff_im = r_prod_im - IM_OFF;

    always_comb begin
        if (r_prod_re > RE_LIM) begin
            o_point.c_re = mec_pkg::Q_MAX;
        end else begin
            o_point.c_re = w_diff_re[mec_pkg::Q_W-1:0];
        end
        if (r_prod_im > IM_LIM) begin
            o_point.c_im = mec_pkg::Q_MAX;
        end else begin
            o_point.c_im = w_diff_im[mec_pkg::Q_W-1:0];
        end
    end

endmodule

// ===== rtl/mec_queue.sv =====
`timescale 1ns / 1ps
// mec_queue: short flop queue of points between front end and engine
// depth set by the package
// depends on mec_pkg
module mec_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  mec_pkg::t_point        i_point,
    input  logic                   i_pop,
    output mec_pkg::t_point        o_point,
    output mec_pkg::t_queue_status o_status
);

    localparam int unsigned DEPTH = mec_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mec_pkg::t_point    r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_point        = r_mem[r_rd_ptr];

    // pointer wrap
    always_comb begin
        n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage, payload only
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_point;
        end
    end

endmodule

// ===== rtl/mec_engine.sv =====
`timescale 1ns / 1ps
// mec_engine: escape-time iteration on one point at a time, then coloring
// each z = z*z + c step runs a multiply state, S_MUL, then an update state, S_UPD
// depends on mec_pkg
module mec_engine #(
    parameter int unsigned ITER_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mec_pkg::t_queue_status        i_q_status,
    input  mec_pkg::t_point               i_point,
    output logic                          o_pop,
    input  logic [ITER_BITS-1:0]          i_iter_limit,
    input  mec_pkg::t_colors              i_colors,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mec_pkg::COLOR_W-1:0]   o_color,
    output mec_pkg::t_region              o_region
);

    localparam int unsigned NW = ITER_BITS + 1;
    localparam int unsigned QW = mec_pkg::Q_W;
    localparam int unsigned SW = mec_pkg::SUM_W;

    mec_pkg::t_eng_state        r_state;
    mec_pkg::t_eng_state        n_state;
    logic signed [QW-1:0]       r_zr, n_zr;
    logic signed [QW-1:0]       r_zi, n_zi;
    logic signed [QW-1:0]       r_cr, n_cr;
    logic signed [QW-1:0]       r_ci, n_ci;
    logic signed [63:0]         r_rr, r_ii, r_ri;
    logic [NW-1:0]              r_n, n_n;
    logic                       r_out_valid, n_out_valid;
    logic [mec_pkg::COLOR_W-1:0] r_color, n_color;
    mec_pkg::t_region           r_region, n_region;

    logic signed [63:0]         w_rr, w_ii, w_ri;
    logic [63:0]                w_mag;
    logic signed [63:0]         w_diff;
    logic signed [SW-1:0]       w_sum_re, w_sum_im;
    logic signed [QW-1:0]       w_new_re, w_new_im;
    logic                       w_stop;
    logic [ITER_BITS-1:0]       w_half;

    // squares and cross product of the current iterate
    assign w_rr = r_zr * r_zr;
    assign w_ii = r_zi * r_zi;
    assign w_ri = r_zr * r_zi;

    // escape test on |z|^2 >= 4 and the count bound
    assign w_mag  = r_rr + r_ii;
    assign w_stop = (|w_mag[63:58]) || (r_n > {1'b0, i_iter_limit});

    // floor shifts back to q4.28, add c
    assign w_diff   = r_rr - r_ii;
    assign w_sum_re = SW'(w_diff >>> mec_pkg::FRAC_W) + SW'(r_cr);
    assign w_sum_im = SW'(r_ri >>> (mec_pkg::FRAC_W - 1)) + SW'(r_ci);

    // clamp to q4.28 when the upper bits disagree with the sign
    always_comb begin
        if (&w_sum_re[SW-1:QW-1] || ~|w_sum_re[SW-1:QW-1]) begin
            w_new_re = w_sum_re[QW-1:0];
        end else begin
            w_new_re = w_sum_re[SW-1] ? mec_pkg::Q_MIN : mec_pkg::Q_MAX;
        end
        if (&w_sum_im[SW-1:QW-1] || ~|w_sum_im[SW-1:QW-1]) begin
            w_new_im = w_sum_im[QW-1:0];
        end else begin
            w_new_im = w_sum_im[SW-1] ? mec_pkg::Q_MIN : mec_pkg::Q_MAX;
        end
    end

    assign w_half = i_iter_limit >> 1;

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_zr        = r_zr;
        n_zi        = r_zi;
        n_cr        = r_cr;
        n_ci        = r_ci;
        n_n         = r_n;
        n_out_valid = r_out_valid && !i_ready;
        n_color     = r_color;
        n_region    = r_region;
        o_pop       = 1'b0;
        unique case (r_state)
            mec_pkg::S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_cr    = i_point.c_re;
                    n_ci    = i_point.c_im;
                    n_zr    = '0;
                    n_zi    = '0;
                    n_n     = '0;
                    n_state = mec_pkg::S_MUL;
                end
            end
            mec_pkg::S_MUL: begin
                n_state = mec_pkg::S_UPD;
            end
            mec_pkg::S_UPD: begin
                if (w_stop) begin
                    n_state = mec_pkg::S_DONE;
                end else begin
                    n_zr    = w_new_re;
                    n_zi    = w_new_im;
                    n_n     = r_n + 1'b1;
                    n_state = mec_pkg::S_MUL;
                end
            end
            mec_pkg::S_DONE: begin
                // wait for a free output register
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    priority if (r_n <= {1'b0, w_half}) begin
                        n_color  = i_colors.outside;
                        n_region = mec_pkg::REGION_OUTSIDE;
                    end else if (r_n < {1'b0, i_iter_limit}) begin
                        n_color  = i_colors.rim;
                        n_region = mec_pkg::REGION_RIM;
                    end else begin
                        n_color  = i_colors.inner;
                        n_region = mec_pkg::REGION_INSIDE;
                    end
                    n_state = mec_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mec_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mec_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_zr     <= n_zr;
        r_zi     <= n_zi;
        r_cr     <= n_cr;
        r_ci     <= n_ci;
        r_n      <= n_n;
        r_color  <= n_color;
        r_region <= n_region;
        if (r_state == mec_pkg::S_MUL) begin
            r_rr <= w_rr;
            r_ii <= w_ii;
            r_ri <= w_ri;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_color  = r_color;
    assign o_region = r_region;

endmodule

// ===== rtl/mandelbrot_escape_classifier.sv =====
`timescale 1ns / 1ps
// mandelbrot_escape_classifier: escape-time pixel classifier, top level
// path: front stage, point queue, multiply/update iteration loop, color register
// n is the final iteration count, at most iteration_limit+1
// the engine takes a new point only after the last pixel has left the shared multiply/update loop
// reset: synchronous active-low, clears control state and reloads the registers
// depends on mec_pkg, mec_front, mec_queue, mec_engine
module mandelbrot_escape_classifier #(
    parameter int unsigned COORD_BITS = 12,
    parameter int unsigned ITER_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mec_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [mec_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [COORD_BITS-1:0]             i_row,
    input  logic [COORD_BITS-1:0]             i_column,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [7:0]                        o_red,
    output logic [7:0]                        o_green,
    output logic [7:0]                        o_blue,
    output logic [1:0]                        o_region
);

    logic [ITER_BITS-1:0]             r_iter_limit;
    logic [mec_pkg::STEP_W-1:0]       r_real_step;
    logic [mec_pkg::STEP_W-1:0]       r_imag_step;
    mec_pkg::t_colors                 r_colors;

    logic                             w_push;
    logic                             w_pop;
    mec_pkg::t_point                  w_front_point;
    mec_pkg::t_point                  w_queue_point;
    mec_pkg::t_queue_status           w_q_status;
    logic [mec_pkg::COLOR_W-1:0]      w_color;
    mec_pkg::t_region                 w_region;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter_limit     <= ITER_BITS'(mec_pkg::RST_ITER_LIMIT);
            r_real_step      <= mec_pkg::RST_REAL_STEP;
            r_imag_step      <= mec_pkg::RST_IMAG_STEP;
            r_colors.inner   <= mec_pkg::RST_INSIDE_COLOR;
            r_colors.rim     <= mec_pkg::RST_RIM_COLOR;
            r_colors.outside <= mec_pkg::RST_OUTSIDE_COLOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                mec_pkg::CFG_ITER_LIMIT: begin
                    r_iter_limit <= i_cfg_data[ITER_BITS-1:0];
                end
                mec_pkg::CFG_REAL_STEP: begin
                    r_real_step <= i_cfg_data;
                end
                mec_pkg::CFG_IMAG_STEP: begin
                    r_imag_step <= i_cfg_data;
                end
                mec_pkg::CFG_INSIDE_COLOR: begin
                    r_colors.inner <= i_cfg_data[mec_pkg::COLOR_W-1:0];
                end
                mec_pkg::CFG_RIM_COLOR: begin
                    r_colors.rim <= i_cfg_data[mec_pkg::COLOR_W-1:0];
                end
                mec_pkg::CFG_OUTSIDE_COLOR: begin
                    r_colors.outside <= i_cfg_data[mec_pkg::COLOR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // front end: coordinate mapping
    mec_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_row       (i_row),
        .i_column    (i_column),
        .i_real_step (r_real_step),
        .i_imag_step (r_imag_step),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_point     (w_front_point)
    );

    // point queue between the two sides
    mec_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_point  (w_front_point),
        .i_pop    (w_pop),
        .o_point  (w_queue_point),
        .o_status (w_q_status)
    );

    // back end: iteration and coloring
    mec_engine #(
        .ITER_BITS (ITER_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_status   (w_q_status),
        .i_point      (w_queue_point),
        .o_pop        (w_pop),
        .i_iter_limit (r_iter_limit),
        .i_colors     (r_colors),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_color      (w_color),
        .o_region     (w_region)
    );

    assign o_red    = w_color[23:16];
    assign o_green  = w_color[15:8];
    assign o_blue   = w_color[7:0];
    assign o_region = w_region;

`ifndef ASSERT_OFF
    // front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.full |-> !w_push)
        else $error("push into full queue");

    // engine never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("pop from empty queue");

    // an inside result carries the inside color
    a_inside_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_region == mec_pkg::REGION_INSIDE)) |->
            (w_color == r_colors.inner))
        else $error("inside result with wrong color");
`endif

endmodule
